// ===== rtl/sclb_pkg.sv =====
`default_nettype none
package sclb_pkg;

  // Channel count and sample format
  localparam int CHANNELS   = 6;
  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 18;
  localparam int FRAC_SHIFT = 16;

  // Stream word: all channels packed from channel 0 up, padded to whole bytes
  localparam int TDATA_W = ((CHANNELS * SAMPLE_W + 7) / 8) * 8;

  // Register port
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  // Datapath widths
  localparam int PROD_W = COEF_W + SAMPLE_W;
  localparam int FF_W   = PROD_W + 2;
  localparam int ACC_W  = PROD_W + 3;

  // Register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_B0  = 3'd0,
    REG_B1  = 3'd1,
    REG_B2  = 3'd2,
    REG_FB1 = 3'd3,
    REG_FB2 = 3'd4
  } reg_idx_t;

  // Coefficient reset values, Q2.16
  localparam logic signed [COEF_W-1:0] B0_RST  = 18'sd859;
  localparam logic signed [COEF_W-1:0] B1_RST  = 18'sd1718;
  localparam logic signed [COEF_W-1:0] B2_RST  = 18'sd859;
  localparam logic signed [COEF_W-1:0] FB1_RST = 18'sd108207;
  localparam logic signed [COEF_W-1:0] FB2_RST = -18'sd46107;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] fb1;
    logic signed [COEF_W-1:0] fb2;
  } coef_t;

  // Pipeline control shared by all lanes
  typedef struct packed {
    logic ld_two;   // priming word 0: sample goes to second history tap
    logic ld_one;   // priming word 1: sample goes to first history tap
    logic ld_run;   // filtering word accepted: shift input history
    logic adv;      // pipeline moves this cycle
    logic run_out;  // word in feedback stage is a filtering word
    logic commit;   // feedback stage result is taken into output history
  } lane_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/sclb_regs.sv =====
`default_nettype none
module sclb_regs (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [sclb_pkg::APB_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [sclb_pkg::APB_DATA_W-1:0]     cfg_pwdata,
  output logic      [sclb_pkg::APB_DATA_W-1:0]     cfg_prdata,
  output logic                                     cfg_pready,
  output sclb_pkg::coef_t                          coef
);

  sclb_pkg::coef_t coef_r;
  logic            wr_en;
  logic [2:0]      idx;
  logic signed [sclb_pkg::COEF_W-1:0] wval;
  logic signed [sclb_pkg::COEF_W-1:0] rval;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign idx        = cfg_paddr[4:2];
  assign wval       = cfg_pwdata[sclb_pkg::COEF_W-1:0];
  assign coef       = coef_r;

  // Coefficient registers; writes past the last register are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.b0  <= sclb_pkg::B0_RST;
      coef_r.b1  <= sclb_pkg::B1_RST;
      coef_r.b2  <= sclb_pkg::B2_RST;
      coef_r.fb1 <= sclb_pkg::FB1_RST;
      coef_r.fb2 <= sclb_pkg::FB2_RST;
    end else if (wr_en) begin
      case (idx)
        sclb_pkg::REG_B0:  coef_r.b0  <= wval;
        sclb_pkg::REG_B1:  coef_r.b1  <= wval;
        sclb_pkg::REG_B2:  coef_r.b2  <= wval;
        sclb_pkg::REG_FB1: coef_r.fb1 <= wval;
        sclb_pkg::REG_FB2: coef_r.fb2 <= wval;
        default: ;
      endcase
    end
  end

  // Read mux, sign-extended to the bus width
  always_comb begin
    case (idx)
      sclb_pkg::REG_B0:  rval = coef_r.b0;
      sclb_pkg::REG_B1:  rval = coef_r.b1;
      sclb_pkg::REG_B2:  rval = coef_r.b2;
      sclb_pkg::REG_FB1: rval = coef_r.fb1;
      sclb_pkg::REG_FB2: rval = coef_r.fb2;
      default:           rval = '0;
    endcase
    cfg_prdata = sclb_pkg::APB_DATA_W'(rval);
  end

endmodule
`default_nettype wire

// ===== rtl/sclb_lane.sv =====
`default_nettype none
module sclb_lane (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire sclb_pkg::coef_t                       coef,
  input  wire sclb_pkg::lane_ctl_t                   ctl,
  input  wire logic signed [sclb_pkg::SAMPLE_W-1:0]  x,
  output logic signed      [sclb_pkg::SAMPLE_W-1:0]  y
);

  localparam int SW  = sclb_pkg::SAMPLE_W;
  localparam int PW  = sclb_pkg::PROD_W;
  localparam int FW  = sclb_pkg::FF_W;
  localparam int AW  = sclb_pkg::ACC_W;
  localparam int SHW = AW - sclb_pkg::FRAC_SHIFT;

  localparam logic signed [AW-1:0]  RND_HALF = AW'(1) <<< (sclb_pkg::FRAC_SHIFT - 1);
  localparam logic signed [SHW-1:0] Y_MAX = {{(SHW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [SHW-1:0] Y_MIN = {{(SHW-SW+1){1'b1}}, {(SW-1){1'b0}}};

  // Input and output history
  logic signed [SW-1:0] xh1_r, xh2_r, yh1_r, yh2_r;

  // Feed-forward products, their sum, and the second feedback term
  logic signed [PW-1:0] pb0_r, pb1_r, pb2_r, fb2t_r;
  logic signed [FW-1:0] ff_r;

  // Feedback stage
  logic signed [PW-1:0]  fb1_prod;
  logic signed [AW-1:0]  acc;
  logic signed [AW-1:0]  rnd;
  logic signed [SHW-1:0] shd;
  logic signed [SW-1:0]  y_sat;
  logic signed [SW-1:0]  y_r;

  assign y = y_r;

  // History: priming loads, then shift on every filtering word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xh1_r <= '0;
      xh2_r <= '0;
      yh1_r <= '0;
      yh2_r <= '0;
    end else begin
      if (ctl.ld_two) xh2_r <= x;
      if (ctl.ld_one) xh1_r <= x;
      if (ctl.ld_run) begin
        xh2_r <= xh1_r;
        xh1_r <= x;
      end
      if (ctl.commit) begin
        yh2_r <= yh1_r;
        yh1_r <= y_sat;
      end
    end
  end

  // Stage 1 products, stage 2 feed-forward sum, output register
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      pb0_r <= coef.b0 * x;
      pb1_r <= coef.b1 * xh1_r;
      pb2_r <= coef.b2 * xh2_r;
      ff_r  <= FW'(pb0_r) + FW'(pb1_r) + FW'(pb2_r);
      y_r   <= ctl.run_out ? y_sat : '0;
    end
  end

  // fb2 * y[n-2] for the next word in the feedback stage; refreshed every cycle
  always_ff @(posedge clk) begin
    fb2t_r <= coef.fb2 * (ctl.commit ? yh1_r : yh2_r);
  end

  // Feedback stage: add fb1 * y[n-1], round half up, saturate
  always_comb begin
    fb1_prod = coef.fb1 * yh1_r;
    acc      = AW'(ff_r) + AW'(fb2t_r) + AW'(fb1_prod);
    rnd      = acc + RND_HALF;
    shd      = SHW'(rnd >>> sclb_pkg::FRAC_SHIFT);
    if (shd > Y_MAX) begin
      y_sat = SW'(Y_MAX);
    end else if (shd < Y_MIN) begin
      y_sat = SW'(Y_MIN);
    end else begin
      y_sat = SW'(shd);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/six_channel_lowpass_biquad_core.sv =====
`default_nettype none
// Six-channel second-order low-pass filter (Butterworth biquad, direct form I).
// Each in_tdata word carries one 24-bit signed sample per channel (8 fraction
// bits); every channel runs the same filter with shared Q2.16 coefficients
// from the register port (b0, b1, b2, fb1, fb2 at byte addresses 0x0..0x10,
// defaults for 5 rad/s cutoff at 0.05 s period). It takes one word per cycle
// unless the output is held and returns one word per input word through the
// product, sum and output registers. The rate is set by the per-channel
// feedback loop: fb1 times the previous output, the final sum, rounding and
// saturation are all combinational. The first two words after reset only
// load the input history and come back with all channels zero and out_tuser
// (settled) low. Write coefficients only while no word is in flight.
module six_channel_lowpass_biquad_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // ch0 [23:0], ch1 [47:24], ch2 [71:48], ch3 [95:72], ch4 [119:96], ch5 [143:120]
  input  wire logic [sclb_pkg::TDATA_W-1:0]         in_tdata,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // ch0 [23:0], ch1 [47:24], ch2 [71:48], ch3 [95:72], ch4 [119:96], ch5 [143:120]
  output logic      [sclb_pkg::TDATA_W-1:0]         out_tdata,
  // settled [0]
  output logic                                      out_tuser,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  input  wire logic                                 cfg_psel,
  input  wire logic                                 cfg_penable,
  input  wire logic                                 cfg_pwrite,
  input  wire logic [sclb_pkg::APB_ADDR_W-1:0]      cfg_paddr,
  input  wire logic [sclb_pkg::APB_DATA_W-1:0]      cfg_pwdata,
  output logic      [sclb_pkg::APB_DATA_W-1:0]      cfg_prdata,
  output logic                                      cfg_pready
);

  localparam int SW = sclb_pkg::SAMPLE_W;
  localparam int CH = sclb_pkg::CHANNELS;

  sclb_pkg::coef_t     coef;
  sclb_pkg::lane_ctl_t ctl;

  logic       adv;
  logic       in_acc;
  logic [1:0] prime_r;
  logic [1:0] prime_nxt;
  logic       s1_vld_r, s1_run_r;
  logic       s2_vld_r, s2_run_r;
  logic       out_vld_r, out_set_r;

  logic signed [SW-1:0] lane_x [CH];
  logic signed [SW-1:0] lane_y [CH];

  sclb_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .coef        (coef)
  );

  // Whole pipeline moves unless the output register is held
  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;
  assign in_acc    = in_tvalid && in_tready;

  // Priming counter: 0, 1, then holds at 2
  assign prime_nxt = (in_acc && !prime_r[1]) ? prime_r + 2'd1 : prime_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_r   <= '0;
      s1_vld_r  <= 1'b0;
      s1_run_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s2_run_r  <= 1'b0;
      out_vld_r <= 1'b0;
      out_set_r <= 1'b0;
    end else begin
      prime_r <= prime_nxt;
      if (adv) begin
        s1_vld_r  <= in_acc;
        s1_run_r  <= prime_r[1];
        s2_vld_r  <= s1_vld_r;
        s2_run_r  <= s1_run_r;
        out_vld_r <= s2_vld_r;
        out_set_r <= s2_run_r;
      end
    end
  end

  // Lane control
  always_comb begin
    ctl.ld_two  = in_acc && (prime_r == 2'd0);
    ctl.ld_one  = in_acc && (prime_r == 2'd1);
    ctl.ld_run  = in_acc && prime_r[1];
    ctl.adv     = adv;
    ctl.run_out = s2_run_r;
    ctl.commit  = adv && s2_vld_r && s2_run_r;
  end

  // One filter lane per channel
  for (genvar i = 0; i < CH; i++) begin : g_lane
    assign lane_x[i] = in_tdata[i*SW +: SW];
    sclb_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .coef  (coef),
      .ctl   (ctl),
      .x     (lane_x[i]),
      .y     (lane_y[i])
    );
  end

  // Merge lane results into the output word
  always_comb begin
    out_tdata = '0;
    for (int i = 0; i < CH; i++) begin
      out_tdata[i*SW +: SW] = lane_y[i];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_set_r;

  // Ready drops only while a finished word is held
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_vld_r && !out_tready))
    else $error("input stalled without output backpressure");

  // Priming counter never passes its hold value
  a_prime_range: assert property (@(posedge clk) disable iff (!rst_n)
    prime_r != 2'd3)
    else $error("priming counter out of range");

  // Priming words come back all zero
  a_prime_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("nonzero output during priming");

  // Right after a settled word has left, no unsettled word is valid
  a_settled_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tuser) |=> !(out_tvalid && !out_tuser))
    else $error("settled flag dropped");

endmodule
`default_nettype wire

// ===== tb/sv/sclb_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the six-channel biquad: follows coefficient writes on the
// register port, predicts each filtered word from the accepted input words
// and compares it with the words leaving the block.
module sclb_checker
  import sclb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [TDATA_W-1:0] in_tdata,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [TDATA_W-1:0] out_tdata,
  input  logic               out_tuser,
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [APB_ADDR_W-1:0] cfg_paddr,
  input  logic [APB_DATA_W-1:0] cfg_pwdata,
  input  logic               cfg_pready,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic               settled;
    logic [TDATA_W-1:0] samples;
  } filt_word_t;

  filt_word_t filtered_q[$];

  // Shadow of the coefficient registers and per-channel filter history
  coef_t                     coefs;
  logic [1:0]                prime_cnt;
  logic signed [SAMPLE_W-1:0] x_one [CHANNELS];
  logic signed [SAMPLE_W-1:0] x_two [CHANNELS];
  logic signed [SAMPLE_W-1:0] y_one [CHANNELS];
  logic signed [SAMPLE_W-1:0] y_two [CHANNELS];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic signed [SAMPLE_W-1:0] clamp_to_sample(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi[SAMPLE_W-1:0];
    if (v < lo) return lo[SAMPLE_W-1:0];
    return v[SAMPLE_W-1:0];
  endfunction

  // One input word through all six biquads; queues the filtered word
  task automatic filter_word(input logic [TDATA_W-1:0] w);
    filt_word_t                 res;
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    longint                     acc;
    res = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      x = w[c*SAMPLE_W +: SAMPLE_W];
      y = '0;
      if (prime_cnt == 2'd0) begin
        x_two[c] = x;
      end else if (prime_cnt == 2'd1) begin
        x_one[c] = x;
      end else begin
        acc = longint'($signed(coefs.b0))  * longint'(x)
            + longint'($signed(coefs.b1))  * longint'(x_one[c])
            + longint'($signed(coefs.b2))  * longint'(x_two[c])
            + longint'($signed(coefs.fb1)) * longint'(y_one[c])
            + longint'($signed(coefs.fb2)) * longint'(y_two[c]);
        // round half up, then floor divide by 2^16
        y = clamp_to_sample((acc + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT);
        y_two[c] = y_one[c];
        y_one[c] = y;
        x_two[c] = x_one[c];
        x_one[c] = x;
      end
      res.samples[c*SAMPLE_W +: SAMPLE_W] = y;
    end
    res.settled = (prime_cnt == 2'd2);
    if (prime_cnt < 2'd2) prime_cnt = prime_cnt + 2'd1;
    filtered_q.push_back(res);
  endtask

  task automatic compare_word();
    filt_word_t want;
    logic [SAMPLE_W-1:0] w_s;
    logic [SAMPLE_W-1:0] g_s;
    if (filtered_q.size() == 0) begin
      $error("output word with no expected word pending");
      fail_count++;
      return;
    end
    want = filtered_q.pop_front();
    for (int c = 0; c < CHANNELS; c++) begin
      w_s = want.samples[c*SAMPLE_W +: SAMPLE_W];
      g_s = out_tdata[c*SAMPLE_W +: SAMPLE_W];
      if (g_s !== w_s) begin
        $error("chan%0d_out: expected %0d, got %0d", c, $signed(w_s), $signed(g_s));
        fail_count++;
      end
    end
    if (out_tuser !== want.settled) begin
      $error("settled: expected %0d, got %0d", want.settled, out_tuser);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      coefs     = '{b0: B0_RST, b1: B1_RST, b2: B2_RST, fb1: FB1_RST, fb2: FB2_RST};
      prime_cnt = '0;
      for (int c = 0; c < CHANNELS; c++) begin
        x_one[c] = '0;
        x_two[c] = '0;
        y_one[c] = '0;
        y_two[c] = '0;
      end
      filtered_q.delete();
    end else begin
      // register write; unmapped indexes are dropped
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[APB_ADDR_W-1:2]))
          REG_B0:  coefs.b0  = cfg_pwdata[COEF_W-1:0];
          REG_B1:  coefs.b1  = cfg_pwdata[COEF_W-1:0];
          REG_B2:  coefs.b2  = cfg_pwdata[COEF_W-1:0];
          REG_FB1: coefs.fb1 = cfg_pwdata[COEF_W-1:0];
          REG_FB2: coefs.fb2 = cfg_pwdata[COEF_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) compare_word();
      if (in_tvalid && in_tready) filter_word(in_tdata);
    end
    pending = filtered_q.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
  import sclb_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_WORDS    = 150;
  localparam int REG_COUNT      = 5;
  localparam int MAX_REG_IDX    = (1 << (APB_ADDR_W - 2)) - 1;
  localparam int WALK_LIM       = (1 << (SAMPLE_W - 1)) - 1;
  localparam logic [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic [COEF_W-1:0]   C_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0]   C_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic [TDATA_W-1:0]    in_tdata    = '0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [TDATA_W-1:0]    out_tdata;
  logic                  out_tuser;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] cfg_paddr   = '0;
  logic [APB_DATA_W-1:0] cfg_pwdata  = '0;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int  fail_count;
  int  pending;
  int  stall_cycles = 0;
  int  words_sent   = 0;
  int  settings     = 1;
  bit  idle_on      = 1'b1;
  int  walk [CHANNELS];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  six_channel_lowpass_biquad_core u_dut (
    .clk, .rst_n,
    .in_tdata, .in_tvalid, .in_tready,
    .out_tdata, .out_tuser, .out_tvalid, .out_tready,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  sclb_checker u_chk (
    .clk, .rst_n,
    .in_tdata, .in_tvalid, .in_tready,
    .out_tdata, .out_tuser, .out_tvalid, .out_tready,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .fail_count, .pending
  );

  // Output side back-pressure
  always @(negedge clk) begin
    out_tready <= idle_on ? ($urandom_range(99) >= 25) : 1'b1;
  end

  // Watchdog: no word moved on any port for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_word(input logic [TDATA_W-1:0] w);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 25) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  task automatic send_uniform(input logic [SAMPLE_W-1:0] s);
    send_word({CHANNELS{s}});
  endtask

  // Drop valid and let every filtered word come back
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic reg_write(input logic [APB_ADDR_W-3:0] idx, input logic [COEF_W-1:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {{(APB_DATA_W-COEF_W){val[COEF_W-1]}}, val};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic load_coefs(input coef_t c);
    reg_write(REG_B0,  c.b0);
    reg_write(REG_B1,  c.b1);
    reg_write(REG_B2,  c.b2);
    reg_write(REG_FB1, c.fb1);
    reg_write(REG_FB2, c.fb2);
    settings++;
  endtask

  function automatic coef_t random_coefs();
    coef_t c;
    if ($urandom_range(1) == 0) begin
      c = '{b0: COEF_W'($urandom), b1: COEF_W'($urandom), b2: COEF_W'($urandom),
            fb1: COEF_W'($urandom), fb2: COEF_W'($urandom)};
    end else begin
      // roughly stable low-pass shapes
      c.b0  = COEF_W'(int'($urandom_range(8192)) - 4096);
      c.b1  = COEF_W'(int'($urandom_range(8192)) - 4096);
      c.b2  = COEF_W'(int'($urandom_range(8192)) - 4096);
      c.fb1 = COEF_W'(int'($urandom_range(120000, 60000)));
      c.fb2 = COEF_W'(-int'($urandom_range(60000, 20000)));
    end
    return c;
  endfunction

  function automatic logic [TDATA_W-1:0] random_word();
    logic [TDATA_W-1:0] w;
    int                 style;
    int                 pick;
    w     = '0;
    style = $urandom_range(9);
    for (int c = 0; c < CHANNELS; c++) begin
      if (style <= 3) begin
        w[c*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'($urandom);
      end else if (style <= 5) begin
        w[c*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'(int'($urandom_range(4000)) - 2000);
      end else if (style == 6) begin
        pick = $urandom_range(3);
        w[c*SAMPLE_W +: SAMPLE_W] = (pick == 0) ? S_MAX : (pick == 1) ? S_MIN :
                                    (pick == 2) ? '0 : '1;
      end else begin
        // slowly moving signal, the usual sensor case
        walk[c] += int'($urandom_range(20000)) - 10000;
        if (walk[c] > WALK_LIM) walk[c] = WALK_LIM;
        if (walk[c] < -WALK_LIM) walk[c] = -WALK_LIM;
        w[c*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'(walk[c]);
      end
    end
    return w;
  endfunction

  task automatic run_random(input int n);
    repeat (n) send_word(random_word());
    drain();
  endtask

  initial begin
    logic [TDATA_W-1:0] w;
    for (int c = 0; c < CHANNELS; c++) walk[c] = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Default coefficients: priming words at the extremes, then steps
    send_uniform(S_MAX);
    send_uniform(S_MIN);
    repeat (6) send_uniform(S_MAX);
    repeat (6) send_uniform(S_MIN);
    repeat (2) send_uniform('0);
    send_uniform({(SAMPLE_W/2){2'b10}});
    send_uniform({(SAMPLE_W/2){2'b01}});
    for (int k = 0; k < 2; k++) begin
      for (int c = 0; c < CHANNELS; c++)
        w[c*SAMPLE_W +: SAMPLE_W] = (k == 0) ? SAMPLE_W'(1 << (c*4)) : SAMPLE_W'(-(1 << (c*4)));
      send_word(w);
    end
    drain();
    run_random(PHASE_WORDS);

    // Largest positive gains, plus writes to unmapped indexes that must be dropped
    load_coefs('{b0: C_MAX, b1: C_MAX, b2: C_MAX, fb1: C_MAX, fb2: C_MAX});
    for (int i = REG_COUNT; i <= MAX_REG_IDX; i++) reg_write((APB_ADDR_W-2)'(i), '0);
    run_random(PHASE_WORDS);

    // Most negative gains
    load_coefs('{b0: C_MIN, b1: C_MIN, b2: C_MIN, fb1: C_MIN, fb2: C_MIN});
    run_random(PHASE_WORDS);

    // Random settings; the first one runs without any idling
    for (int p = 0; p < 3; p++) begin
      idle_on = (p != 0);
      load_coefs(random_coefs());
      run_random(PHASE_WORDS);
    end
    idle_on = 1'b1;

    // Back to the design defaults
    load_coefs('{b0: B0_RST, b1: B1_RST, b2: B2_RST, fb1: FB1_RST, fb2: FB2_RST});
    run_random(PHASE_WORDS);

    $display("Sent %0d sample words over %0d coefficient settings: priming, extreme",
             words_sent, settings);
    $display("gains with saturation, random designs and dropped unmapped writes.");
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sclb_pkg.sv
rtl/sclb_regs.sv
rtl/sclb_lane.sv
rtl/six_channel_lowpass_biquad_core.sv
tb/sv/sclb_checker.sv
tb/sv/tb_top.sv
